### src/tls_pkg.sv
// shared types, register indexes and reset values for the traffic light sequencer
package tls_pkg;

  localparam int unsigned CfgWidth = 8;
  localparam int unsigned AddrWidth = 4;
  localparam int unsigned DataWidth = 32;

  localparam logic [1:0] RegGreen = 2'd0;
  localparam logic [1:0] RegRed = 2'd1;
  localparam logic [1:0] RegBlink = 2'd2;
  localparam logic [1:0] RegConfirm = 2'd3;

  localparam logic [CfgWidth-1:0] GreenReset = 8'd10;
  localparam logic [CfgWidth-1:0] RedReset = 8'd10;
  localparam logic [CfgWidth-1:0] BlinkReset = 8'd10;
  localparam logic [CfgWidth-1:0] ConfirmReset = 8'd2;

  typedef enum logic [3:0] {
    PhGreen  = 4'b0001,
    PhBlinkA = 4'b0010,
    PhRed    = 4'b0100,
    PhBlinkB = 4'b1000
  } car_phase_e;

  typedef enum logic [4:0] {
    WsIdle    = 5'b00001,
    WsConfirm = 5'b00010,
    WsBlink1  = 5'b00100,
    WsWalk    = 5'b01000,
    WsBlink2  = 5'b10000
  } walk_step_e;

  typedef struct packed {
    logic [CfgWidth-1:0] green_ticks;
    logic [CfgWidth-1:0] red_ticks;
    logic [CfgWidth-1:0] blink_ticks;
    logic [CfgWidth-1:0] confirm_ticks;
  } cfg_t;

  typedef struct packed {
    logic car_red;
    logic car_yellow;
    logic car_green;
    logic walk_red;
    logic walk_yellow;
    logic walk_green;
  } lamps_t;

endpackage

### src/tls_in_if.sv
// tick request channel carrying the button level
interface tls_in_if;
  logic valid;
  logic ready;
  logic button_level;

  modport source (output valid, output button_level, input ready);
  modport sink (input valid, input button_level, output ready);
endinterface

### src/tls_out_if.sv
// lamp result channel
interface tls_out_if;
  logic valid;
  logic ready;
  logic car_red;
  logic car_yellow;
  logic car_green;
  logic walk_red;
  logic walk_yellow;
  logic walk_green;

  modport source (output valid, output car_red, output car_yellow, output car_green,
                  output walk_red, output walk_yellow, output walk_green, input ready);
  modport sink (input valid, input car_red, input car_yellow, input car_green,
                input walk_red, input walk_yellow, input walk_green, output ready);
endinterface

### src/traffic_light_pedestrian_sequencer_top.sv
// top level of the traffic light sequencer with pedestrian button
//
// in_ch carries one half-second tick per request with the button level.
// out_ch returns one request per tick with the six lamp levels of that
// tick: car red/yellow/green and pedestrian red/yellow/green.
// A tick accepted at one edge shows its lamps on out_ch from the next
// cycle. Throughput is one tick per cycle while out_ch is not stalled;
// the sequencer state updates in a single pass at acceptance and the
// lamps land in one result register.
// in_ch.ready is high whenever the result register is empty or is being
// taken in the same cycle, so a stalled receiver holds the result and
// stops further ticks until it drains.
// Durations are set through the apb port (green, red, blink, confirm at
// byte addresses 0, 4, 8, 12); write them only while no tick is in flight.
// Reset puts the car cycle at the start of green with the pedestrian
// sequence idle, restores default durations and empties the result register.
module traffic_light_pedestrian_sequencer_top
  import tls_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  tls_in_if.sink               in_ch,
  tls_out_if.source            out_ch,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready
);

  cfg_t cfg;
  lamps_t lamps_next, lamps_held;
  logic accept, out_valid;

  assign in_ch.ready = ~out_valid | out_ch.ready;
  assign accept = in_ch.valid & in_ch.ready;

  tls_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tls_seq_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .button_i (in_ch.button_level),
    .cfg_i    (cfg),
    .lamps_o  (lamps_next)
  );

  tls_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept),
    .lamps_i (lamps_next),
    .ready_i (out_ch.ready),
    .valid_o (out_valid),
    .lamps_o (lamps_held)
  );

  assign out_ch.valid = out_valid;
  assign out_ch.car_red = lamps_held.car_red;
  assign out_ch.car_yellow = lamps_held.car_yellow;
  assign out_ch.car_green = lamps_held.car_green;
  assign out_ch.walk_red = lamps_held.walk_red;
  assign out_ch.walk_yellow = lamps_held.walk_yellow;
  assign out_ch.walk_green = lamps_held.walk_green;

`ifndef SYNTHESIS
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_ch.valid)
    else $error("accepted tick left no result");

  a_one_red_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> !(out_ch.walk_green && out_ch.car_green))
    else $error("car green together with pedestrian green");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(lamps_held))
    else $error("lamp result changed while stalled");
`endif

endmodule

### src/tls_cfg_regs.sv
// apb register file holding the phase durations
module tls_cfg_regs
  import tls_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr_en = psel & penable & pwrite;
  assign idx = paddr[AddrWidth-1:2];
  assign cfg_o = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        RegGreen:   cfg_d.green_ticks = pwdata[CfgWidth-1:0];
        RegRed:     cfg_d.red_ticks = pwdata[CfgWidth-1:0];
        RegBlink:   cfg_d.blink_ticks = pwdata[CfgWidth-1:0];
        RegConfirm: cfg_d.confirm_ticks = pwdata[CfgWidth-1:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      RegGreen:   prdata[CfgWidth-1:0] = cfg_q.green_ticks;
      RegRed:     prdata[CfgWidth-1:0] = cfg_q.red_ticks;
      RegBlink:   prdata[CfgWidth-1:0] = cfg_q.blink_ticks;
      RegConfirm: prdata[CfgWidth-1:0] = cfg_q.confirm_ticks;
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.green_ticks <= GreenReset;
      cfg_q.red_ticks <= RedReset;
      cfg_q.blink_ticks <= BlinkReset;
      cfg_q.confirm_ticks <= ConfirmReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### src/tls_seq_core.sv
// sequencer state: car phase, pedestrian step, tick counters and lamp decode
module tls_seq_core
  import tls_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   accept_i,
  input  logic   button_i,
  input  cfg_t   cfg_i,
  output lamps_t lamps_o
);

  car_phase_e ph_q, ph_d;
  walk_step_e ws_q, ws_d, ws1;
  logic [CfgWidth-1:0] pt_q, pt_d, pt1;
  logic [CfgWidth-1:0] cc_q, cc_d, cc_dec;
  logic bl_q, bl_d, bl1;
  logic prev_q;
  logic rise, phase_end, start;
  logic [CfgWidth-1:0] dur;

  assign rise = button_i & ~prev_q;
  assign cc_dec = (cc_q != '0) ? cc_q - 1'b1 : cc_q;

  // button handling comes before the lamps of this tick
  always_comb begin
    start = 1'b0;
    ws1 = ws_q;
    cc_d = cc_q;
    unique case (ws_q)
      WsIdle: begin
        if (rise) begin
          if (cfg_i.confirm_ticks == '0) begin
            start = 1'b1;
          end else begin
            cc_d = cfg_i.confirm_ticks;
            ws1 = WsConfirm;
          end
        end
      end
      WsConfirm: begin
        cc_d = cc_dec;
        if (cc_dec == '0) begin
          if (button_i) start = 1'b1;
          else ws1 = WsIdle;
        end
      end
      default: ws1 = ws_q;
    endcase
    if (start) ws1 = (ph_q == PhRed) ? WsWalk : WsBlink1;
  end

  assign pt1 = start ? '0 : pt_q;
  assign bl1 = start ? 1'b0 : bl_q;

  always_comb begin
    lamps_o = '0;
    unique case (ws1)
      WsBlink1: begin
        lamps_o.car_yellow = bl1;
        lamps_o.walk_yellow = bl1;
        lamps_o.walk_red = 1'b1;
      end
      WsWalk: begin
        lamps_o.car_red = 1'b1;
        lamps_o.walk_green = 1'b1;
      end
      WsBlink2: begin
        lamps_o.car_yellow = bl1;
        lamps_o.walk_yellow = bl1;
        lamps_o.walk_green = 1'b1;
      end
      default: begin
        lamps_o.walk_red = 1'b1;
        unique case (ph_q)
          PhGreen: lamps_o.car_green = 1'b1;
          PhRed:   lamps_o.car_red = 1'b1;
          default: lamps_o.car_yellow = bl1;
        endcase
      end
    endcase
  end

  always_comb begin
    unique case (ws1)
      WsBlink1, WsBlink2: dur = cfg_i.blink_ticks;
      WsWalk:             dur = cfg_i.red_ticks;
      default: begin
        unique case (ph_q)
          PhGreen: dur = cfg_i.green_ticks;
          PhRed:   dur = cfg_i.red_ticks;
          default: dur = cfg_i.blink_ticks;
        endcase
      end
    endcase
  end

  // zero duration acts as one tick
  assign phase_end = ({1'b0, pt1} + 9'd1) >= {1'b0, dur};

  always_comb begin
    ws_d = ws1;
    ph_d = ph_q;
    bl_d = ~bl1;
    pt_d = pt1 + 1'b1;
    if (phase_end) begin
      pt_d = '0;
      bl_d = 1'b0;
      unique case (ws1)
        WsBlink1: ws_d = WsWalk;
        WsWalk:   ws_d = WsBlink2;
        WsBlink2: begin
          ws_d = WsIdle;
          ph_d = PhGreen;
        end
        default: begin
          unique case (ph_q)
            PhGreen:  ph_d = PhBlinkA;
            PhBlinkA: ph_d = PhRed;
            PhRed:    ph_d = PhBlinkB;
            default:  ph_d = PhGreen;
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PhGreen;
      ws_q <= WsIdle;
      pt_q <= '0;
      cc_q <= '0;
      bl_q <= 1'b0;
      prev_q <= 1'b0;
    end else if (accept_i) begin
      ph_q <= ph_d;
      ws_q <= ws_d;
      pt_q <= pt_d;
      cc_q <= cc_d;
      bl_q <= bl_d;
      prev_q <= button_i;
    end
  end

`ifndef SYNTHESIS
  a_confirm_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ws_q == WsConfirm) |-> (cc_q != '0))
    else $error("confirm wait with zero count");

  a_ticks_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pt_q != {CfgWidth{1'b1}})
    else $error("phase tick count beyond longest duration");

  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept_i |=> $stable(ws_q) && $stable(ph_q) && $stable(pt_q))
    else $error("state moved without a request");
`endif

endmodule

### src/tls_out_stage.sv
// result register holding the lamp levels until taken
module tls_out_stage
  import tls_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   load_i,
  input  lamps_t lamps_i,
  input  logic   ready_i,
  output logic   valid_o,
  output lamps_t lamps_o
);

  logic valid_q, valid_d;
  lamps_t lamps_q;

  assign valid_d = load_i | (valid_q & ~ready_i);
  assign valid_o = valid_q;
  assign lamps_o = lamps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) lamps_q <= lamps_i;
  end

endmodule

### verif/tb_traffic_light_pedestrian_sequencer_top.sv
// testbench for the traffic light sequencer: lamp prediction, random ticks and idling
module tb_traffic_light_pedestrian_sequencer_top;
  import tls_pkg::*;

  localparam int unsigned QuietLimit = 2000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [DataWidth-1:0] pwdata;
  logic [DataWidth-1:0] prdata;
  logic                 pready;

  tls_in_if  in_ch ();
  tls_out_if out_ch ();

  traffic_light_pedestrian_sequencer_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // lamp order follows the packed bits of lamps_t, walk_green is bit 0
  string lamp_names [6] = '{"walk_green", "walk_yellow", "walk_red",
                            "car_green", "car_yellow", "car_red"};

  // sequencer model state
  cfg_t        dur_cfg;
  car_phase_e  car_st;
  walk_step_e  walk_st;
  logic [7:0]  spent;
  logic        blink_lvl;
  logic [7:0]  confirm_left;
  logic        btn_prev;

  lamps_t      lamp_expect_q[$];
  int unsigned err_count;
  int unsigned ticks_sent;
  int unsigned results_seen;
  int unsigned walks_started;
  int unsigned settings_used;
  int unsigned quiet_cycles;
  int unsigned stall_left;
  bit          idle_on;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_error(input string msg);
    err_count++;
    if (err_count <= 20) $display("error at %0t: %s", $time, msg);
  endtask

  function automatic int unsigned pick_pause();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void begin_walk();
    walk_st = (car_st == PhRed) ? WsWalk : WsBlink1;
    spent = '0;
    blink_lvl = 1'b0;
    walks_started++;
  endfunction

  function automatic lamps_t predict_lamps(input logic level);
    logic       rise;
    logic       bl;
    logic [7:0] len;
    lamps_t     l;
    rise = level && !btn_prev;
    btn_prev = level;
    case (walk_st)
      WsIdle: begin
        if (rise) begin
          if (dur_cfg.confirm_ticks == '0) begin
            begin_walk();
          end else begin
            confirm_left = dur_cfg.confirm_ticks;
            walk_st = WsConfirm;
          end
        end
      end
      WsConfirm: begin
        if (confirm_left != '0) confirm_left--;
        if (confirm_left == '0) begin
          if (level) begin_walk();
          else walk_st = WsIdle;
        end
      end
      default: ;
    endcase

    bl = blink_lvl;
    l = '0;
    case (walk_st)
      WsBlink1: begin
        l.car_yellow = bl;
        l.walk_yellow = bl;
        l.walk_red = 1'b1;
      end
      WsWalk: begin
        l.car_red = 1'b1;
        l.walk_green = 1'b1;
      end
      WsBlink2: begin
        l.car_yellow = bl;
        l.walk_yellow = bl;
        l.walk_green = 1'b1;
      end
      default: begin
        l.walk_red = 1'b1;
        if (car_st == PhGreen) l.car_green = 1'b1;
        else if (car_st == PhRed) l.car_red = 1'b1;
        else l.car_yellow = bl;
      end
    endcase

    // duration of the phase or step this tick belongs to
    case (walk_st)
      WsBlink1, WsBlink2: len = dur_cfg.blink_ticks;
      WsWalk: len = dur_cfg.red_ticks;
      default: begin
        if (car_st == PhGreen) len = dur_cfg.green_ticks;
        else if (car_st == PhRed) len = dur_cfg.red_ticks;
        else len = dur_cfg.blink_ticks;
      end
    endcase

    blink_lvl = ~bl;
    if ({1'b0, spent} + 9'd1 >= {1'b0, len}) begin
      spent = '0;
      blink_lvl = 1'b0;
      case (walk_st)
        WsBlink1: walk_st = WsWalk;
        WsWalk: walk_st = WsBlink2;
        WsBlink2: begin
          walk_st = WsIdle;
          car_st = PhGreen;
        end
        default: begin
          case (car_st)
            PhGreen: car_st = PhBlinkA;
            PhBlinkA: car_st = PhRed;
            PhRed: car_st = PhBlinkB;
            default: car_st = PhGreen;
          endcase
        end
      endcase
    end else begin
      spent = spent + 8'd1;
    end
    return l;
  endfunction

  task automatic send_tick(input logic level);
    int unsigned gap;
    gap = pick_pause();
    @(negedge clk_i);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.button_level <= level;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    lamp_expect_q.push_back(predict_lamps(level));
    ticks_sent++;
  endtask

  task automatic send_level(input logic level, input int unsigned n);
    repeat (n) send_tick(level);
  endtask

  // stop sending and wait until every tick has shown its lamps
  task automatic drain(input int unsigned extra);
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (lamp_expect_q.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrWidth'({idx, 2'b00});
    pwdata <= DataWidth'(val);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    case (idx)
      RegGreen: dur_cfg.green_ticks = val;
      RegRed: dur_cfg.red_ticks = val;
      RegBlink: dur_cfg.blink_ticks = val;
      default: dur_cfg.confirm_ticks = val;
    endcase
    // read it back
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (prdata[CfgWidth-1:0] !== val)
      report_error($sformatf("register %0d read %0h, wrote %0h",
                             idx, prdata[CfgWidth-1:0], val));
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_durations(input logic [7:0] g, input logic [7:0] r, input logic [7:0] b,
                               input logic [7:0] c);
    write_cfg(RegGreen, g);
    write_cfg(RegRed, r);
    write_cfg(RegBlink, b);
    write_cfg(RegConfirm, c);
    settings_used++;
  endtask

  function automatic logic [7:0] pick_duration();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) return 8'd0;
    if (r < 14) return 8'd1;
    if (r < 96) return 8'($urandom_range(2, 8));
    return 8'($urandom_range(20, 60));
  endfunction

  function automatic logic [7:0] pick_confirm();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return 8'd0;
    if (r < 30) return 8'd1;
    if (r < 95) return 8'($urandom_range(2, 5));
    return 8'($urandom_range(10, 30));
  endfunction

  // a few ticks on reset durations
  task automatic test_reset_defaults();
    send_level(1'b0, 4);
  endtask

  // confirm of zero starts the sequence on the edge tick, zero durations act as one
  task automatic test_zero_confirm();
    drain(2);
    set_durations(8'd0, 8'd1, 8'd2, 8'd0);
    send_level(1'b0, 1);
    send_level(1'b1, 2);
    // edge during the sequence must be ignored
    send_level(1'b0, 1);
    send_level(1'b1, 1);
    send_level(1'b0, 3);
  endtask

  // pressed while the car is red, the walk starts without the first blink
  task automatic test_walk_from_red();
    while (!(car_st == PhRed && walk_st == WsIdle)) send_tick(1'b0);
    send_level(1'b1, 1);
    send_level(1'b0, 4);
  endtask

  // released at the confirm sample goes back to idle, held starts the walk
  task automatic test_confirm_release();
    drain(2);
    set_durations(8'd2, 8'd1, 8'd1, 8'd1);
    send_level(1'b1, 1);
    send_level(1'b0, 2);
    send_level(1'b1, 2);
    send_level(1'b0, 1);
  endtask

  // a green duration lowered below the ticks already spent ends green next tick
  task automatic test_duration_lowered();
    drain(2);
    set_durations(8'd200, 8'd1, 8'd1, 8'd2);
    while (!(car_st == PhGreen && walk_st == WsIdle && spent >= 8'd4)) send_tick(1'b0);
    drain(2);
    write_cfg(RegGreen, 8'd3);
    send_level(1'b0, 2);
  endtask

  task automatic random_ticks(input int unsigned count);
    int unsigned start;
    int unsigned k;
    start = ticks_sent;
    while (ticks_sent - start < count) begin
      k = $urandom_range(0, 99);
      if (k < 2) drain(0);
      if (k < 60) begin
        // press held through the confirm sample
        send_level(1'b1, int'(dur_cfg.confirm_ticks) + 1 + $urandom_range(0, 2));
        send_level(1'b0, $urandom_range(1, 15));
      end else if (k < 80 && dur_cfg.confirm_ticks != '0) begin
        // released before the confirm sample
        send_level(1'b1, $urandom_range(1, int'(dur_cfg.confirm_ticks)));
        send_level(1'b0, $urandom_range(1, 6));
      end else begin
        repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < 12; p++) begin
      drain(2);
      idle_on = (p % 3 != 1);
      if (p == 4) begin
        // long confirm holds overshoot the count by a whole press
        set_durations(8'd255, 8'd1, 8'd1, 8'd255);
        random_ticks(150);
      end else if (p == 8) begin
        set_durations(8'd1, 8'd255, 8'd255, 8'd0);
        random_ticks(300);
      end else begin
        set_durations(pick_duration(), pick_duration(), pick_duration(), pick_confirm());
        random_ticks(100);
      end
    end
    idle_on = 1'b1;
  endtask

  // receiver side stalls
  initial begin
    out_ch.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_pause();
      end
    end
  end

  always @(posedge clk_i) begin : check_lamps
    lamps_t got;
    lamps_t want;
    if (rst_ni && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = {out_ch.car_red, out_ch.car_yellow, out_ch.car_green,
             out_ch.walk_red, out_ch.walk_yellow, out_ch.walk_green};
      if (lamp_expect_q.size() == 0) begin
        report_error("lamp result with no tick waiting");
      end else begin
        want = lamp_expect_q.pop_front();
        for (int i = 5; i >= 0; i--) begin
          if (got[i] !== want[i])
            report_error($sformatf("result %0d: %s expected %0b got %0b",
                                   results_seen, lamp_names[i], want[i], got[i]));
        end
      end
      results_seen++;
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("timeout after %0d idle cycles", quiet_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.button_level = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    dur_cfg = '{green_ticks: GreenReset, red_ticks: RedReset,
                blink_ticks: BlinkReset, confirm_ticks: ConfirmReset};
    car_st = PhGreen;
    walk_st = WsIdle;
    spent = '0;
    blink_lvl = 1'b0;
    confirm_left = '0;
    btn_prev = 1'b0;
    err_count = 0;
    ticks_sent = 0;
    results_seen = 0;
    walks_started = 0;
    settings_used = 1;
    quiet_cycles = 0;
    idle_on = 1'b1;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_zero_confirm();
    test_walk_from_red();
    test_confirm_release();
    test_duration_lowered();
    test_random_traffic();

    drain(4);
    if (lamp_expect_q.size() != 0)
      report_error($sformatf("%0d lamp results never arrived", lamp_expect_q.size()));
    $display("sent %0d ticks over %0d duration settings, checked %0d lamp results",
             ticks_sent, settings_used, results_seen);
    $display("pedestrian sequences started: %0d", walks_started);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
src/tls_pkg.sv
src/tls_in_if.sv
src/tls_out_if.sv
src/tls_cfg_regs.sv
src/tls_seq_core.sv
src/tls_out_stage.sv
src/traffic_light_pedestrian_sequencer_top.sv
verif/tb_traffic_light_pedestrian_sequencer_top.sv
